@@ sv/keypad_mode_led_controller_defines.svh @@
// Assertion macros shared by the keypad mode LED controller RTL.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef KEYPAD_MODE_LED_CONTROLLER_DEFINES_SVH
`define KEYPAD_MODE_LED_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KMLC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KMLC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/kmlc_pkg.sv @@
// Types, codes and LED tables for the keypad mode LED controller.
// No dependencies; used by every other file of the block but the macro header.
package kmlc_pkg;

  typedef logic [4:0] mode_t;
  typedef logic [3:0] keys_t;
  typedef logic [5:0] leds_t;
  typedef logic [1:0] cfg_idx_t;
  typedef logic [7:0] tick_t;

  // Operating modes
  localparam mode_t MODE_RUN           = 5'd0;
  localparam mode_t MODE_IN_CAL        = 5'd1;
  localparam mode_t MODE_IN_LOW        = 5'd2;
  localparam mode_t MODE_IN_HIGH       = 5'd3;
  localparam mode_t MODE_IN_DONE       = 5'd4;
  localparam mode_t MODE_OUT_CAL       = 5'd5;
  localparam mode_t MODE_OUT_LOW       = 5'd6;
  localparam mode_t MODE_OUT_HIGH      = 5'd7;
  localparam mode_t MODE_OUT_DONE      = 5'd8;
  localparam mode_t MODE_SAVE_CAL      = 5'd9;
  localparam mode_t MODE_STORE_DONE    = 5'd10;
  localparam mode_t MODE_RECALL_CAL    = 5'd11;
  localparam mode_t MODE_RESTORE_DONE  = 5'd12;
  localparam mode_t MODE_SENSOR_BROKEN = 5'd13;
  localparam mode_t MODE_COMM_FAIL     = 5'd14;
  localparam mode_t MODE_MEM_CORRUPT   = 5'd15;
  localparam mode_t MODE_PWM_CHK       = 5'd16;
  localparam mode_t MODE_COUNT         = 5'd17;

  // Key codes
  localparam keys_t KEY_SET = 4'b0001;
  localparam keys_t KEY_UP  = 4'b0010;
  localparam keys_t KEY_DN  = 4'b0100;
  localparam keys_t KEY_ENT = 4'b1000;
  localparam keys_t KEYS_SET_DOWN   = KEY_SET | KEY_DN;
  localparam keys_t KEYS_SET_UP     = KEY_SET | KEY_UP;
  localparam keys_t KEYS_UP_ENTER   = KEY_UP | KEY_ENT;
  localparam keys_t KEYS_DOWN_ENTER = KEY_DN | KEY_ENT;

  // Lone-key codes
  localparam logic [1:0] SINGLE_NONE = 2'd0;
  localparam logic [1:0] SINGLE_UP   = 2'd1;
  localparam logic [1:0] SINGLE_DOWN = 2'd2;

  // Item kinds
  localparam logic FUNC_SCAN  = 1'b0;
  localparam logic FUNC_FORCE = 1'b1;

  // Configuration register indexes and reset values
  localparam cfg_idx_t CFG_SHORT_HOLD = 2'd0;
  localparam cfg_idx_t CFG_LONG_HOLD  = 2'd1;
  localparam cfg_idx_t CFG_FLASH      = 2'd2;
  localparam tick_t SHORT_HOLD_RST = 8'd50;
  localparam tick_t LONG_HOLD_RST  = 8'd100;
  localparam tick_t FLASH_RST      = 8'd5;

  typedef struct packed {
    logic  func;
    keys_t keys;
    mode_t forced_mode;
  } kmlc_item_t;

  typedef struct packed {
    tick_t short_hold_ticks;
    tick_t long_hold_ticks;
    tick_t flash_ticks;
  } kmlc_cfg_t;

  typedef struct packed {
    mode_t      mode;
    logic       cal_active;
    leds_t      led_levels;
    logic [1:0] single_key;
  } kmlc_result_t;

  // LEDs lit steadily in each mode
  function automatic leds_t lit_mask(mode_t m);
    leds_t r;
    case (m)
      MODE_IN_CAL, MODE_IN_LOW:     r = 6'd8;
      MODE_IN_HIGH:                 r = 6'd12;
      MODE_IN_DONE:                 r = 6'd14;
      MODE_OUT_CAL, MODE_OUT_LOW:   r = 6'd1;
      MODE_OUT_HIGH:                r = 6'd5;
      MODE_OUT_DONE:                r = 6'd7;
      MODE_STORE_DONE:              r = 6'd6;
      MODE_RESTORE_DONE:            r = 6'd9;
      MODE_COMM_FAIL:               r = 6'd48;
      default:                      r = 6'd0;
    endcase
    return r;
  endfunction

  // LEDs that flash in each mode
  function automatic leds_t flash_mask(mode_t m);
    leds_t r;
    case (m)
      MODE_IN_LOW, MODE_OUT_LOW:    r = 6'd4;
      MODE_IN_HIGH, MODE_OUT_HIGH:  r = 6'd2;
      MODE_SAVE_CAL:                r = 6'd6;
      MODE_RECALL_CAL:              r = 6'd9;
      MODE_SENSOR_BROKEN:           r = 6'd16;
      MODE_MEM_CORRUPT:             r = 6'd48;
      MODE_PWM_CHK:                 r = 6'd15;
      default:                      r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/kmlc_if.sv @@
// Valid/ready channel interfaces for the keypad mode LED controller.
// Depends on kmlc_pkg for the payload field types.
interface kmlc_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  kmlc_pkg::keys_t    keys;
  kmlc_pkg::mode_t    forced_mode;

  modport source (output valid, output func, output keys, output forced_mode, input ready);
  modport sink   (input valid, input func, input keys, input forced_mode, output ready);
endinterface

interface kmlc_out_if;
  logic               valid;
  logic               ready;
  kmlc_pkg::mode_t    mode;
  logic               cal_active;
  kmlc_pkg::leds_t    led_levels;
  logic [1:0]         single_key;

  modport source (output valid, output mode, output cal_active, output led_levels,
                  output single_key, input ready);
  modport sink   (input valid, input mode, input cal_active, input led_levels,
                  input single_key, output ready);
endinterface

@@ sv/kmlc_led_dec.sv @@
// Mode to LED pin level decoder (active-low pins, flashing LEDs follow the phase).
// Depends on kmlc_pkg for the LED tables.
module kmlc_led_dec (
  input  kmlc_pkg::mode_t mode,
  input  logic            flash_phase,
  output kmlc_pkg::leds_t led_levels
);
  import kmlc_pkg::*;

  leds_t lit;
  leds_t fl;

  assign lit = lit_mask(mode);
  assign fl  = flash_mask(mode);

  // Low where lit or flashing; flashing LEDs go dark again on the high phase.
  assign led_levels = ~(lit | fl) | (flash_phase ? fl : '0);
endmodule

@@ sv/kmlc_core.sv @@
// Mode state and next-state logic: hold counter, armed ENTER, flash phase.
// Depends on kmlc_pkg and the assertion macro header.
`include "keypad_mode_led_controller_defines.svh"

module kmlc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  kmlc_pkg::kmlc_item_t item,
  input  kmlc_pkg::kmlc_cfg_t  cfg,
  output kmlc_pkg::mode_t      mode_nxt,
  output logic                 cal_nxt,
  output logic                 flash_phase_nxt,
  output logic [1:0]           single_key
);
  import kmlc_pkg::*;

  mode_t mode_r;
  logic  cal_r;
  logic  first_tick_r, first_tick_nxt;
  keys_t held_combo_r, held_combo_nxt;
  tick_t hold_count_r, hold_count_nxt;
  logic  enter_armed_r, enter_armed_nxt;
  tick_t flash_count_r, flash_count_nxt;
  logic  flash_phase_r;

  // Combination decode
  logic  combo_hit;
  tick_t combo_limit;
  mode_t combo_target;
  logic  combo_cal;
  tick_t hold_base;
  tick_t hold_inc;
  tick_t flash_inc;

  // Checker helpers
  logic  cal_mode_ok;
  logic  scan_step;

  always_comb begin
    combo_hit    = 1'b1;
    combo_limit  = cfg.short_hold_ticks;
    combo_target = MODE_IN_CAL;
    combo_cal    = 1'b1;
    case (item.keys)
      KEYS_SET_DOWN: begin
        combo_target = MODE_IN_CAL;
      end
      KEYS_SET_UP: begin
        combo_target = MODE_OUT_CAL;
      end
      KEYS_UP_ENTER: begin
        combo_limit  = cfg.long_hold_ticks;
        combo_target = MODE_RECALL_CAL;
        combo_cal    = 1'b0;
      end
      KEYS_DOWN_ENTER: begin
        combo_target = MODE_PWM_CHK;
      end
      default: begin
        combo_hit = 1'b0;
      end
    endcase
  end

  // Restart on a new combination, saturate at the top.
  assign hold_base = (held_combo_r == item.keys) ? hold_count_r : '0;
  assign hold_inc  = (hold_base == '1) ? hold_base : hold_base + 8'd1;
  assign flash_inc = (flash_count_r == '1) ? flash_count_r : flash_count_r + 8'd1;

  always_comb begin
    mode_nxt        = mode_r;
    cal_nxt         = cal_r;
    first_tick_nxt  = first_tick_r;
    held_combo_nxt  = held_combo_r;
    hold_count_nxt  = hold_count_r;
    enter_armed_nxt = enter_armed_r;
    flash_count_nxt = flash_count_r;
    flash_phase_nxt = flash_phase_r;
    single_key      = SINGLE_NONE;
    if (step_en) begin
      if (item.func == FUNC_FORCE) begin
        if (item.forced_mode < MODE_COUNT) begin
          mode_nxt = item.forced_mode;
          cal_nxt  = (item.forced_mode >= MODE_IN_CAL) && (item.forced_mode <= MODE_OUT_DONE);
        end
      end else begin
        if (flash_inc >= cfg.flash_ticks) begin
          flash_phase_nxt = ~flash_phase_r;
          flash_count_nxt = '0;
        end else begin
          flash_count_nxt = flash_inc;
        end
        if (item.keys == KEY_UP) begin
          single_key = SINGLE_UP;
        end else if (item.keys == KEY_DN) begin
          single_key = SINGLE_DOWN;
        end
        first_tick_nxt = 1'b0;
        held_combo_nxt = '0;
        hold_count_nxt = '0;
        if (first_tick_r && item.keys == KEYS_DOWN_ENTER) begin
          mode_nxt = MODE_SAVE_CAL;
          cal_nxt  = 1'b0;
        end else if (enter_armed_r) begin
          // Step the chain on ENTER release.
          if ((item.keys & KEY_ENT) == '0) begin
            enter_armed_nxt = 1'b0;
            case (mode_r) inside
              MODE_IN_CAL, MODE_IN_LOW, MODE_IN_HIGH,
              MODE_OUT_CAL, MODE_OUT_LOW, MODE_OUT_HIGH: begin
                mode_nxt = mode_r + 5'd1;
                cal_nxt  = 1'b1;
              end
              MODE_IN_DONE, MODE_OUT_DONE, MODE_SAVE_CAL,
              MODE_RECALL_CAL, MODE_PWM_CHK: begin
                mode_nxt = MODE_RUN;
                cal_nxt  = 1'b0;
              end
              default: begin
                mode_nxt = mode_r;
              end
            endcase
          end
        end else if (item.keys == KEY_ENT) begin
          enter_armed_nxt = 1'b1;
        end else if (!cal_r && combo_hit) begin
          held_combo_nxt = item.keys;
          if (hold_inc >= combo_limit) begin
            mode_nxt       = combo_target;
            cal_nxt        = combo_cal;
            hold_count_nxt = '0;
          end else begin
            hold_count_nxt = hold_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_RUN;
      cal_r         <= 1'b0;
      first_tick_r  <= 1'b1;
      held_combo_r  <= '0;
      hold_count_r  <= '0;
      enter_armed_r <= 1'b0;
      flash_count_r <= '0;
      flash_phase_r <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      cal_r         <= cal_nxt;
      first_tick_r  <= first_tick_nxt;
      held_combo_r  <= held_combo_nxt;
      hold_count_r  <= hold_count_nxt;
      enter_armed_r <= enter_armed_nxt;
      flash_count_r <= flash_count_nxt;
      flash_phase_r <= flash_phase_nxt;
    end
  end

  assign cal_mode_ok = ((mode_r >= MODE_IN_CAL) && (mode_r <= MODE_OUT_DONE)) ||
                       (mode_r == MODE_PWM_CHK);
  assign scan_step   = step_en && (item.func == FUNC_SCAN);

  `KMLC_ASSERT_IMP(a_cal_mode, cal_r, cal_mode_ok, "calibration flag in a non-cal mode")
  `KMLC_ASSERT_IMP(a_armed_clear, enter_armed_r, (held_combo_r == '0 && hold_count_r == '0), "hold count while armed")
  `KMLC_ASSERT_IMP(a_first_fall, $fell(first_tick_r), $past(scan_step), "power-on flag cleared early")
  `KMLC_ASSERT_IMP(a_mode_range, 1'b1, (mode_r < MODE_COUNT), "mode register out of range")
endmodule

@@ sv/keypad_mode_led_controller.sv @@
// Top level of the keypad mode LED controller: channel registers and config.
// Depends on kmlc_pkg, kmlc_if, kmlc_core, kmlc_led_dec and the macro header.
//
// Usage:
//   in_ch  carries one item per transfer: a scan tick (func 0) with the
//          debounced key set, or a forced mode write (func 1).
//   out_ch returns exactly one result per item: mode, calibration flag,
//          six active-low LED levels and the lone-key code.
//   cfg_*  writes the hold and flash tick counts; write only while idle.
// Timing:
//   An accepted item is held in the input register, is evaluated
//   against the mode state by one pass of compare/increment/decode logic and
//   lands in the output register once that slot is free: the result passes
//   through both registers before it can transfer. One item per cycle is
//   sustained while out_ch.ready stays high.
// Reset (rst_n low, synchronous): both channel stages empty, normal mode,
//   power-on flag set, counters and flash phase cleared, config at defaults.
// Stall: while out_ch.ready is low the result holds and the input register
//   still fills; in_ch.ready drops only when both stages are full.
`include "keypad_mode_led_controller_defines.svh"

module keypad_mode_led_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  kmlc_in_if.sink              in_ch,
  kmlc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  kmlc_pkg::cfg_idx_t   cfg_idx,
  input  kmlc_pkg::tick_t      cfg_wdata
);
  import kmlc_pkg::*;

  // Configuration registers
  kmlc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_hold_ticks <= SHORT_HOLD_RST;
      cfg_r.long_hold_ticks  <= LONG_HOLD_RST;
      cfg_r.flash_ticks      <= FLASH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SHORT_HOLD: cfg_r.short_hold_ticks <= cfg_wdata;
        CFG_LONG_HOLD:  cfg_r.long_hold_ticks  <= cfg_wdata;
        CFG_FLASH:      cfg_r.flash_ticks      <= cfg_wdata;
        default:        cfg_r                  <= cfg_r;
      endcase
    end
  end

  // Input stage
  logic       in_valid_r;
  kmlc_item_t item_r;
  logic       advance;
  logic       in_xfer;

  // Output stage
  logic         out_valid_r;
  kmlc_result_t res_r;
  kmlc_result_t res_nxt;
  logic         phase_nxt;
  logic         both_full;

  // Move the held item into the result register when that slot frees up.
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.func        <= in_ch.func;
      item_r.keys        <= in_ch.keys;
      item_r.forced_mode <= in_ch.forced_mode;
    end
  end

  kmlc_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (advance),
    .item            (item_r),
    .cfg             (cfg_r),
    .mode_nxt        (res_nxt.mode),
    .cal_nxt         (res_nxt.cal_active),
    .flash_phase_nxt (phase_nxt),
    .single_key      (res_nxt.single_key)
  );

  // LEDs follow the updated mode and phase.
  kmlc_led_dec u_led_dec (
    .mode        (res_nxt.mode),
    .flash_phase (phase_nxt),
    .led_levels  (res_nxt.led_levels)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.mode       = res_r.mode;
  assign out_ch.cal_active = res_r.cal_active;
  assign out_ch.led_levels = res_r.led_levels;
  assign out_ch.single_key = res_r.single_key;

  assign both_full = in_valid_r && out_valid_r && !out_ch.ready;

  `KMLC_ASSERT_IMP(a_ready_low, !in_ch.ready, both_full, "input stalled with a free stage")
  `KMLC_ASSERT_NXT(a_adv_out, advance, out_valid_r, "result lost after advance")
  `KMLC_ASSERT_NXT(a_xfer_hold, (in_xfer && !advance), in_valid_r, "accepted item dropped")
endmodule
